/* rtl/core/box_collision_test_assert.svh */
// ----------------------------------------------------------------------------
// Box collision test assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef BOX_COLLISION_TEST_ASSERT_SVH
`define BOX_COLLISION_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCT_ASSERT_NOW(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
		else $error(MSG);

// The consequent must hold in the cycle after the antecedent.
`define BCT_ASSERT_NEXT(LABEL, CLK, RST_N, ANTE, CONS, MSG) \
	LABEL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
		else $error(MSG);

`endif

/* rtl/core/bct_pkg.sv */
// ----------------------------------------------------------------------------
// Box collision test package
// Shared constants, command and register codes, and item types.
// ----------------------------------------------------------------------------
package bct_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_X = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_Y = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_Z = 3'd5;

	localparam logic [1:0] CMD_BOX = 2'd0;
	localparam logic [1:0] CMD_SPHERE = 2'd1;
	localparam logic [1:0] CMD_POINT = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic [30:0] radius;
	} req_t;

	typedef struct packed {
		logic hit;
		logic signed [31:0] push_x;
		logic signed [31:0] push_y;
		logic signed [31:0] push_z;
	} rsp_t;

	typedef struct packed {
		logic [2:0][32:0] lo;
		logic [2:0][32:0] hi;
		logic [2:0][31:0] center;
	} box_t;

endpackage

/* rtl/core/box_collision_test.sv */
// ----------------------------------------------------------------------------
// Box collision test
// Streams box, sphere and point tests against one stored axis-aligned box.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the output stall backs up
// the pipeline, and delivers its result through five pipeline stages that each
// advance on their own, so bubbles close up while the output is stalled. The
// squared distance of the sphere test sets the depth: it needs a stage for its
// multipliers, one for the sum of squares and one for the final compare. A
// register write takes effect for items accepted from the next cycle on, and
// the write port is always ready.
module box_collision_test #(
	parameter int FRAC_BITS = bct_pkg::FRAC_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input bct_pkg::req_t req_item,
	output logic rsp_valid,
	input logic rsp_stall,
	output bct_pkg::rsp_t rsp_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bct_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [bct_pkg::CFG_DATA_W-1:0] cfg_data
);

	`include "box_collision_test_assert.svh"

	localparam logic signed [33:0] SAT_POS = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] SAT_NEG = 34'sh0_8000_0000;

	bct_pkg::box_t box;
	logic signed [32:0] own_lo [3];
	logic signed [32:0] own_hi [3];
	logic signed [33:0] ctr2 [3];
	logic signed [33:0] pe [3];
	logic signed [33:0] qe [3];

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [1:0] cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [30:0] r_s1, r_s2;
	logic signed [33:0] oa_s1 [3];
	logic signed [33:0] ob_s1 [3];
	logic signed [33:0] pq_s1 [3];
	logic signed [33:0] ctr2_s1 [3];
	logic signed [33:0] dlo_s1 [3];
	logic signed [33:0] dhi_s1 [3];

	logic signed [33:0] o_s2 [3];
	logic [2:0] neg_s2;
	logic [30:0] ad_s2 [3];
	logic box_hit_s2, box_hit_s3, box_hit_s4;
	logic point_s2, point_s3, point_s4;
	logic far_s2, far_s3, far_s4;

	logic signed [33:0] mag_s3;
	logic neg_s3;
	logic [2:0] axis_s3, axis_s4;
	logic [61:0] sq_s3 [3];
	logic [61:0] rr_s3, rr_s4;

	logic [63:0] sum_s4;
	logic signed [31:0] push_s4;

	bct_pkg::rsp_t rsp_s5;

	logic signed [33:0] oa_d [3];
	logic signed [33:0] ob_d [3];
	logic signed [33:0] pq_d [3];
	logic signed [33:0] dlo_d [3];
	logic signed [33:0] dhi_d [3];
	logic signed [33:0] o_d [3];
	logic [2:0] neg_d;
	logic [2:0] box_ok_d;
	logic [2:0] in_d;
	logic [2:0] far_d;
	logic [30:0] ad_d [3];
	logic signed [33:0] r_ext;
	logic [2:0] axis_d;
	logic signed [33:0] mag_d;
	logic neg_sel_d;
	logic signed [31:0] push_d;
	logic hit_d;
	logic box_push;

	assign cfg_ready = 1'b1;

	bct_box_regs #(
		.FRAC_BITS(FRAC_BITS)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.box(box)
	);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			own_lo[a] = box.lo[a];
			own_hi[a] = box.hi[a];
			ctr2[a] = {box.center[a][31], box.center[a], 1'b0};
		end
	end

	assign rdy5 = !valid_s5 || !rsp_stall;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign req_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= req_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage 1 forms every difference against the corners.
	always_comb begin
		pe[0] = {{2{req_item.first_x[31]}}, req_item.first_x};
		pe[1] = {{2{req_item.first_y[31]}}, req_item.first_y};
		pe[2] = {{2{req_item.first_z[31]}}, req_item.first_z};
		qe[0] = {{2{req_item.second_x[31]}}, req_item.second_x};
		qe[1] = {{2{req_item.second_y[31]}}, req_item.second_y};
		qe[2] = {{2{req_item.second_z[31]}}, req_item.second_z};
		for (int a = 0; a < 3; a++) begin
			oa_d[a] = {own_hi[a][32], own_hi[a]} - pe[a];
			ob_d[a] = qe[a] - {own_lo[a][32], own_lo[a]};
			pq_d[a] = pe[a] + qe[a];
			dlo_d[a] = {own_lo[a][32], own_lo[a]} - pe[a];
			dhi_d[a] = pe[a] - {own_hi[a][32], own_hi[a]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1 <= req_item.cmd;
			r_s1 <= req_item.radius;
			for (int a = 0; a < 3; a++) begin
				oa_s1[a] <= oa_d[a];
				ob_s1[a] <= ob_d[a];
				pq_s1[a] <= pq_d[a];
				ctr2_s1[a] <= ctr2[a];
				dlo_s1[a] <= dlo_d[a];
				dhi_s1[a] <= dhi_d[a];
			end
		end
	end

	// Stage 2 takes per-axis overlaps, sides and clamped distances.
	assign r_ext = {3'b000, r_s1};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			o_d[a] = (oa_s1[a] <= ob_s1[a]) ? oa_s1[a] : ob_s1[a];
			box_ok_d[a] = !oa_s1[a][33] && !ob_s1[a][33];
			neg_d[a] = ctr2_s1[a] < pq_s1[a];
			in_d[a] = !(dlo_s1[a] > 34'sd0) && !(dhi_s1[a] > 34'sd0);
			far_d[a] = (dlo_s1[a] > r_ext) || (dhi_s1[a] > r_ext);
			if (dlo_s1[a] > 34'sd0) begin
				ad_d[a] = dlo_s1[a][30:0];
			end else if (dhi_s1[a] > 34'sd0) begin
				ad_d[a] = dhi_s1[a][30:0];
			end else begin
				ad_d[a] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			cmd_s2 <= cmd_s1;
			r_s2 <= r_s1;
			neg_s2 <= neg_d;
			box_hit_s2 <= &box_ok_d;
			point_s2 <= &in_d;
			far_s2 <= |far_d;
			for (int a = 0; a < 3; a++) begin
				o_s2[a] <= o_d[a];
				ad_s2[a] <= ad_d[a];
			end
		end
	end

	// Stage 3 picks the least-overlap axis and squares the distances.
	always_comb begin
		priority if (o_s2[0] <= o_s2[1] && o_s2[0] <= o_s2[2]) begin
			axis_d = 3'b001;
			mag_d = o_s2[0];
			neg_sel_d = neg_s2[0];
		end else if (o_s2[1] <= o_s2[2]) begin
			axis_d = 3'b010;
			mag_d = o_s2[1];
			neg_sel_d = neg_s2[1];
		end else begin
			axis_d = 3'b100;
			mag_d = o_s2[2];
			neg_sel_d = neg_s2[2];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			cmd_s3 <= cmd_s2;
			box_hit_s3 <= box_hit_s2;
			point_s3 <= point_s2;
			far_s3 <= far_s2;
			axis_s3 <= axis_d;
			mag_s3 <= mag_d;
			neg_s3 <= neg_sel_d;
			rr_s3 <= r_s2 * r_s2;
			for (int a = 0; a < 3; a++) begin
				sq_s3[a] <= ad_s2[a] * ad_s2[a];
			end
		end
	end

	// Stage 4 sums the squares and saturates the signed push.
	always_comb begin
		if (neg_s3) begin
			push_d = (mag_s3 > SAT_NEG) ? 32'sh8000_0000 : 32'(-mag_s3);
		end else begin
			push_d = (mag_s3 > SAT_POS) ? 32'sh7FFF_FFFF : mag_s3[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			cmd_s4 <= cmd_s3;
			box_hit_s4 <= box_hit_s3;
			point_s4 <= point_s3;
			far_s4 <= far_s3;
			axis_s4 <= axis_s3;
			push_s4 <= push_d;
			rr_s4 <= rr_s3;
			sum_s4 <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
		end
	end

	// Stage 5 selects the answer of the requested test.
	always_comb begin
		unique case (cmd_s4)
			bct_pkg::CMD_BOX: hit_d = box_hit_s4;
			bct_pkg::CMD_SPHERE: hit_d = !far_s4 && (sum_s4 <= 64'(rr_s4));
			bct_pkg::CMD_POINT: hit_d = point_s4;
			bct_pkg::CMD_NONE: hit_d = 1'b0;
		endcase
	end

	assign box_push = (cmd_s4 == bct_pkg::CMD_BOX) && box_hit_s4;

	always_ff @(posedge clk) begin
		if (rdy5) begin
			rsp_s5.hit <= hit_d;
			rsp_s5.push_x <= (box_push && axis_s4[0]) ? push_s4 : '0;
			rsp_s5.push_y <= (box_push && axis_s4[1]) ? push_s4 : '0;
			rsp_s5.push_z <= (box_push && axis_s4[2]) ? push_s4 : '0;
		end
	end

	assign rsp_valid = valid_s5;
	assign rsp_item = rsp_s5;

	`BCT_ASSERT_NOW(a_push_needs_hit, clk, arst_n, rsp_valid && !rsp_item.hit, rsp_item.push_x == 0 && rsp_item.push_y == 0 && rsp_item.push_z == 0, "push without a hit")
	`BCT_ASSERT_NOW(a_single_push_axis, clk, arst_n, rsp_valid, $countones({rsp_item.push_x != 0, rsp_item.push_y != 0, rsp_item.push_z != 0}) <= 1, "push on more than one axis")
	`BCT_ASSERT_NEXT(a_no_repeat, clk, arst_n, rsp_valid && !rsp_stall && !valid_s4, !rsp_valid, "result item repeated")
	`BCT_ASSERT_NOW(a_stall_when_full, clk, arst_n, req_stall, valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5, "input stalled with room in the pipeline")
	`BCT_ASSERT_NOW(a_corner_order, clk, arst_n, 1'b1, own_lo[0] <= own_hi[0] && own_lo[1] <= own_hi[1] && own_lo[2] <= own_hi[2], "box corners out of order")

endmodule

/* rtl/core/bct_box_regs.sv */
// ----------------------------------------------------------------------------
// Box collision test box registers
// Holds center and extent per axis and keeps the min and max corners current.
// ----------------------------------------------------------------------------
module bct_box_regs #(
	parameter int FRAC_BITS = bct_pkg::FRAC_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bct_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [bct_pkg::CFG_DATA_W-1:0] cfg_data,
	output bct_pkg::box_t box
);

	localparam logic [30:0] EXTENT_RST = 31'(1 << FRAC_BITS);
	localparam logic signed [32:0] HALF_RST = 33'(1 << (FRAC_BITS - 1));

	logic signed [31:0] center_q [3];
	logic [30:0] extent_q [3];
	logic signed [32:0] lo_q [3];
	logic signed [32:0] hi_q [3];

	logic [2:0] ctr_we;
	logic [2:0] ext_we;
	logic signed [32:0] data_ext;
	logic signed [32:0] half_new;
	logic signed [32:0] half_old [3];
	logic signed [32:0] center_ext [3];

	always_comb begin
		ctr_we = '0;
		ext_we = '0;
		unique case (cfg_index)
			bct_pkg::REG_CENTER_X: ctr_we[0] = cfg_we;
			bct_pkg::REG_CENTER_Y: ctr_we[1] = cfg_we;
			bct_pkg::REG_CENTER_Z: ctr_we[2] = cfg_we;
			bct_pkg::REG_EXTENT_X: ext_we[0] = cfg_we;
			bct_pkg::REG_EXTENT_Y: ext_we[1] = cfg_we;
			bct_pkg::REG_EXTENT_Z: ext_we[2] = cfg_we;
			default: ;
		endcase
	end

	assign data_ext = {cfg_data[31], cfg_data};
	assign half_new = {3'b000, cfg_data[30:1]};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			half_old[a] = {3'b000, extent_q[a][30:1]};
			center_ext[a] = {center_q[a][31], center_q[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				center_q[a] <= '0;
				extent_q[a] <= EXTENT_RST;
				lo_q[a] <= -HALF_RST;
				hi_q[a] <= HALF_RST;
			end
		end else begin
			for (int a = 0; a < 3; a++) begin
				if (ctr_we[a]) begin
					center_q[a] <= cfg_data;
					lo_q[a] <= data_ext - half_old[a];
					hi_q[a] <= data_ext + half_old[a];
				end else if (ext_we[a]) begin
					extent_q[a] <= cfg_data[30:0];
					lo_q[a] <= center_ext[a] - half_new;
					hi_q[a] <= center_ext[a] + half_new;
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			box.lo[a] = lo_q[a];
			box.hi[a] = hi_q[a];
			box.center[a] = center_q[a];
		end
	end

endmodule
